[rtl/assert_macros.svh]
// Assertion macros used by escalating_pin_lockout.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check with a fixed message.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clocked assertion failed");

// Clocked check with a caller message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

[rtl/epl_pkg.sv]
// Types, constants and codes for the escalating PIN lockout block.
package epl_pkg;

    localparam int TIME_BITS  = 64;
    localparam int CNT_W      = 32;
    localparam int ATT_W      = 16;
    localparam int DUR_W      = 32;
    localparam int NUM_TIERS  = 4;
    localparam int TIER_W     = 3;
    localparam int TIER_IDX_W = 2;
    localparam int CMD_W      = 3;
    localparam int OUTCOME_W  = 2;
    localparam int NOW_W      = 64;
    localparam int REM_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    localparam time_t              TIME_MAX  = '1;
    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PROVISION = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_BOOT      = 3'd2,
        CMD_REPORT    = 3'd3,
        CMD_QUERY     = 3'd4
    } command_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_SUCCESS   = 2'd0,
        OUTCOME_WRONG_PIN = 2'd1,
        OUTCOME_INVALID   = 2'd2,
        OUTCOME_OTHER     = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        VERDICT_VERIFIED = 3'd0,
        VERDICT_REJECTED = 3'd1,
        VERDICT_LOCKED   = 3'd2,
        VERDICT_MISSING  = 3'd3,
        VERDICT_INVALID  = 3'd4,
        VERDICT_ERROR    = 3'd5,
        VERDICT_DONE     = 3'd6
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIER1_ATTEMPTS = 3'd0,
        REG_TIER2_ATTEMPTS = 3'd1,
        REG_TIER3_ATTEMPTS = 3'd2,
        REG_TIER4_ATTEMPTS = 3'd3,
        REG_TIER1_DURATION = 3'd4,
        REG_TIER2_DURATION = 3'd5,
        REG_TIER3_DURATION = 3'd6,
        REG_TIER4_DURATION = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                  provisioned;
        logic [CNT_W-1:0]      failed_count;
        logic [TIER_W-1:0]     lock_level;
        time_t                 lock_deadline;
    } lock_state_t;

    typedef struct packed {
        logic [NUM_TIERS-1:0][ATT_W-1:0] attempts;
        logic [NUM_TIERS-1:0][DUR_W-1:0] duration;
    } tier_cfg_t;

    typedef struct packed {
        verdict_t              verdict;
        logic                  record_present;
        logic                  is_locked;
        logic [REM_W-1:0]      remaining_ms;
        logic [TIER_W-1:0]     tier_out;
        logic [CNT_W-1:0]      failures_out;
        logic                  relock_key;
    } result_t;

    localparam lock_state_t STATE_EMPTY = '{
        provisioned:   1'b0,
        failed_count:  '0,
        lock_level:    '0,
        lock_deadline: '0
    };

    localparam tier_cfg_t CFG_RESET = '{
        attempts: {16'd20, 16'd15, 16'd10, 16'd5},
        duration: {32'd86400000, 32'd7200000, 32'd1800000, 32'd300000}
    };

endpackage

[rtl/epl_core.sv]
// Command evaluation: next lock state and result for one command.
module epl_core
    import epl_pkg::*;
(
    input  lock_state_t            st,
    input  tier_cfg_t              cfg,
    input  logic [CMD_W-1:0]       command,
    input  logic [OUTCOME_W-1:0]   check_outcome,
    input  logic [NOW_W-1:0]       now_ms,
    output lock_state_t            st_next,
    output result_t                res
);

    time_t                                now_t;
    logic [CNT_W-1:0]                     cnt_inc;
    logic [NUM_TIERS-1:0]                 reached;
    logic [TIER_W-1:0]                    new_tier;
    logic [NUM_TIERS-1:0][TIME_BITS:0]    sum_ext;
    time_t [NUM_TIERS-1:0]                arm_deadline_all;
    time_t [NUM_TIERS-1:0]                arm_rem_all;
    logic [TIER_W-1:0]                    arm_tier;
    logic [TIER_IDX_W-1:0]                arm_idx;
    time_t                                arm_deadline;
    time_t                                arm_rem;
    logic [TIME_BITS:0]                   diff_ext;
    logic                                 later_old;
    logic                                 lock_from_old;
    logic                                 lock_from_arm;
    logic                                 locked;
    time_t                                rem;
    verdict_t                             verdict;
    logic                                 relock;

    assign now_t   = now_ms[TIME_BITS-1:0];
    assign cnt_inc = (st.failed_count == COUNT_MAX) ? st.failed_count
                                                    : st.failed_count + CNT_W'(1);

    always_comb
    begin
        for (int i = 0; i < NUM_TIERS; i++)
        begin
            reached[i] = cnt_inc >= CNT_W'(cfg.attempts[i]);
        end
    end

    // Thresholds are taken in tier order: stop at the first one not reached.
    always_comb
    begin
        priority if (!reached[0])
            new_tier = TIER_W'(0);
        else if (!reached[1])
            new_tier = TIER_W'(1);
        else if (!reached[2])
            new_tier = TIER_W'(2);
        else if (!reached[3])
            new_tier = TIER_W'(3);
        else
            new_tier = TIER_W'(4);
    end

    // One saturating deadline per tier; the carry out marks overflow past TIME_MAX.
    always_comb
    begin
        for (int i = 0; i < NUM_TIERS; i++)
        begin
            sum_ext[i] = {1'b0, now_t} + (TIME_BITS + 1)'(cfg.duration[i]);
            if (sum_ext[i][TIME_BITS])
            begin
                arm_deadline_all[i] = TIME_MAX;
                arm_rem_all[i]      = ~now_t;
            end
            else
            begin
                arm_deadline_all[i] = sum_ext[i][TIME_BITS-1:0];
                arm_rem_all[i]      = TIME_BITS'(cfg.duration[i]);
            end
        end
    end

    assign arm_tier     = (command == CMD_BOOT) ? st.lock_level : new_tier;
    assign arm_idx      = TIER_IDX_W'(arm_tier - TIER_W'(1));
    assign arm_deadline = arm_deadline_all[arm_idx];
    assign arm_rem      = arm_rem_all[arm_idx];

    assign diff_ext  = {1'b0, st.lock_deadline} - {1'b0, now_t};
    assign later_old = !diff_ext[TIME_BITS] && (diff_ext[TIME_BITS-1:0] != '0);

    always_comb
    begin
        st_next       = st;
        verdict       = VERDICT_DONE;
        relock        = 1'b0;
        lock_from_old = 1'b0;
        lock_from_arm = 1'b0;

        unique case (command)
            CMD_PROVISION:
            begin
                st_next             = STATE_EMPTY;
                st_next.provisioned = 1'b1;
            end
            CMD_CLEAR:
            begin
                st_next = STATE_EMPTY;
            end
            CMD_BOOT:
            begin
                if (!st.provisioned)
                    verdict = VERDICT_MISSING;
                else if (st.lock_level != '0)
                begin
                    st_next.lock_deadline = arm_deadline;
                    lock_from_arm         = 1'b1;
                end
            end
            CMD_REPORT:
            begin
                relock = 1'b1;
                if (!st.provisioned)
                    verdict = VERDICT_MISSING;
                else
                begin
                    unique case (outcome_t'(check_outcome))
                        OUTCOME_SUCCESS:
                        begin
                            st_next.failed_count  = '0;
                            st_next.lock_level    = '0;
                            st_next.lock_deadline = '0;
                            verdict               = VERDICT_VERIFIED;
                            relock                = 1'b0;
                        end
                        OUTCOME_WRONG_PIN:
                        begin
                            st_next.failed_count = cnt_inc;
                            if (new_tier != '0)
                            begin
                                st_next.lock_level    = new_tier;
                                st_next.lock_deadline = arm_deadline;
                                verdict               = VERDICT_LOCKED;
                                lock_from_arm         = 1'b1;
                            end
                            else
                            begin
                                verdict       = VERDICT_REJECTED;
                                relock        = 1'b0;
                                lock_from_old = 1'b1;
                            end
                        end
                        OUTCOME_INVALID:
                        begin
                            verdict       = VERDICT_INVALID;
                            lock_from_old = 1'b1;
                        end
                        OUTCOME_OTHER:
                        begin
                            verdict       = VERDICT_ERROR;
                            lock_from_old = 1'b1;
                        end
                        default:
                        begin
                            verdict       = VERDICT_ERROR;
                            lock_from_old = 1'b1;
                        end
                    endcase
                end
            end
            CMD_QUERY:
            begin
                if (!st.provisioned)
                    verdict = VERDICT_MISSING;
                else if (st.lock_level != '0 && !later_old)
                begin
                    // expired lock: drop tier and deadline
                    st_next.lock_level    = '0;
                    st_next.lock_deadline = '0;
                end
                else
                    lock_from_old = 1'b1;
            end
            default:
            begin
                verdict       = VERDICT_ERROR;
                lock_from_old = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        locked = 1'b0;
        rem    = '0;
        if (lock_from_arm)
        begin
            locked = arm_rem != '0;
            rem    = arm_rem;
        end
        else if (lock_from_old)
        begin
            locked = st.provisioned && (st.lock_level != '0) && later_old;
            rem    = diff_ext[TIME_BITS-1:0];
        end
    end

    assign res = '{
        verdict:        verdict,
        record_present: st_next.provisioned,
        is_locked:      locked,
        remaining_ms:   locked ? REM_W'(rem) : '0,
        tier_out:       locked ? st_next.lock_level : '0,
        failures_out:   st_next.provisioned ? st_next.failed_count : '0,
        relock_key:     relock
    };

endmodule

[rtl/escalating_pin_lockout.sv]
// Escalating PIN lockout guard: attempt record, tier thresholds and lock timing.
//
// Input channel (in_valid/in_ready) carries one command with check_outcome and
// now_ms; output channel (out_valid/out_ready) returns exactly one result per
// command, in order. A transfer happens when valid and ready are both high.
// A command lands in an input register, is evaluated against the attempt record
// combinationally, and its result is registered; out_valid rises when the result
// register is loaded. One command per cycle is sustained while out_ready is high;
// the record update, the tier compares and the deadline add are all combinational.
// When the receiver stalls, the result register holds and the input register
// takes one more command; in_ready then drops until out_ready returns.
// Tier thresholds and durations are written through cfg_wr_en/cfg_index/cfg_data
// by the user only while the block is idle; the block does not enforce this.
// Reset (rst_n low, asynchronous) restores their defaults, empties both registers
// and clears the record: not provisioned, zero failures, tier 0, deadline 0.
`include "assert_macros.svh"

module escalating_pin_lockout
    import epl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic [OUTCOME_W-1:0]     check_outcome,
    input  logic [NOW_W-1:0]         now_ms,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               verdict,
    output logic                     record_present,
    output logic                     is_locked,
    output logic [REM_W-1:0]         remaining_ms,
    output logic [TIER_W-1:0]        tier_out,
    output logic [CNT_W-1:0]         failures_out,
    output logic                     relock_key
);

    tier_cfg_t               cfg_reg;
    lock_state_t             st_reg;
    lock_state_t             st_next;

    logic                    in_valid_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [OUTCOME_W-1:0]    outcome_reg;
    logic [NOW_W-1:0]        now_reg;

    logic                    out_valid_reg;
    result_t                 res_reg;
    result_t                 res_next;

    logic                    advance;
    logic                    fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TIER1_ATTEMPTS: cfg_reg.attempts[0] <= cfg_data[ATT_W-1:0];
                REG_TIER2_ATTEMPTS: cfg_reg.attempts[1] <= cfg_data[ATT_W-1:0];
                REG_TIER3_ATTEMPTS: cfg_reg.attempts[2] <= cfg_data[ATT_W-1:0];
                REG_TIER4_ATTEMPTS: cfg_reg.attempts[3] <= cfg_data[ATT_W-1:0];
                REG_TIER1_DURATION: cfg_reg.duration[0] <= cfg_data[DUR_W-1:0];
                REG_TIER2_DURATION: cfg_reg.duration[1] <= cfg_data[DUR_W-1:0];
                REG_TIER3_DURATION: cfg_reg.duration[2] <= cfg_data[DUR_W-1:0];
                REG_TIER4_DURATION: cfg_reg.duration[3] <= cfg_data[DUR_W-1:0];
                default:            cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input register: hold until the evaluation stage can advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg     <= command;
            outcome_reg <= check_outcome;
            now_reg     <= now_ms;
        end
    end

    epl_core u_core (
        .st            (st_reg),
        .cfg           (cfg_reg),
        .command       (cmd_reg),
        .check_outcome (outcome_reg),
        .now_ms        (now_reg),
        .st_next       (st_next),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= STATE_EMPTY;
        else if (fire)
            st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = res_reg.verdict;
    assign record_present = res_reg.record_present;
    assign is_locked      = res_reg.is_locked;
    assign remaining_ms   = res_reg.remaining_ms;
    assign tier_out       = res_reg.tier_out;
    assign failures_out   = res_reg.failures_out;
    assign relock_key     = res_reg.relock_key;

    `ASSERT_CLK_MSG(a_no_deadline_without_tier, clk, rst_n, (st_reg.lock_level == '0) |-> (st_reg.lock_deadline == '0), "lock deadline set while tier is zero")
    `ASSERT_CLK_MSG(a_absent_record_empty, clk, rst_n, !st_reg.provisioned |-> (st_reg.failed_count == '0 && st_reg.lock_level == '0), "record absent but count or tier nonzero")
    `ASSERT_CLK_MSG(a_locked_result_sane, clk, rst_n, (out_valid_reg && res_reg.is_locked) |-> (res_reg.tier_out != '0 && res_reg.remaining_ms != '0), "locked result without tier or time left")
    `ASSERT_CLK(a_stall_holds_input, clk, rst_n, (in_valid_reg && out_valid_reg && !out_ready) |=> (in_valid_reg && $stable(now_reg) && $stable(st_reg)))

endmodule
